@@ rtl/acm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants of the autoscaling false-color mapper.
// ----------------------------------------------------------------------------
package acm_pkg;

   localparam logic [1:0] MODE_PAL_WRITE = 2'd0;
   localparam logic [1:0] MODE_MEASURE   = 2'd1;
   localparam logic [1:0] MODE_MAP       = 2'd2;
   localparam logic [1:0] MODE_CLEAR     = 2'd3;

   localparam logic [0:0] REG_PALETTE_ENABLE = 1'd0;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] sample;
      logic [7:0]         pal_index;
      logic [23:0]        pal_rgb;
   } req_type;

   typedef struct packed {
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       log_scaled;
   } rsp_type;

   // Datapath operations selected by the controller.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_LOG_START,
      OP_LOG_STEP,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_FINISH
   } op_type;

   // Which operand the log unit takes.
   typedef enum logic [1:0] {
      LSRC_MIN,
      LSRC_MAX,
      LSRC_SAMPLE
   } lsrc_type;

   typedef struct packed {
      op_type   op;
      lsrc_type lsrc;
   } cmd_type;

   typedef struct packed {
      logic use_log;
      logic logs_ready;
   } status_type;

endpackage

@@ rtl/acm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer: walks a map item through log and division steps.
// ----------------------------------------------------------------------------
module acm_ctrl #(
   parameter int LOG_FRAC_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  logic [1:0]          item_mode,
   output logic                busy,
   input  acm_pkg::status_type status,
   output acm_pkg::cmd_type    cmd,
   output logic                done
);

   localparam int CW = $clog2(LOG_FRAC_BITS + 1) + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_LMIN, S_LMAX, S_LSMP, S_DIV, S_RD, S_FIN
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd.op   = acm_pkg::OP_NONE;
      cmd.lsrc = acm_pkg::LSRC_SAMPLE;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               cmd.op = acm_pkg::OP_LOAD;
               if (item_mode == acm_pkg::MODE_MAP) begin
                  if (status.use_log && !status.logs_ready) begin
                     state_in = S_LMIN;
                  end else if (status.use_log) begin
                     state_in = S_LSMP;
                  end else begin
                     state_in = S_DIV;
                  end
                  count_in = '0;
               end
            end
         end
         S_LMIN, S_LMAX, S_LSMP: begin
            cmd.lsrc = (state_ff == S_LMIN) ? acm_pkg::LSRC_MIN :
                       (state_ff == S_LMAX) ? acm_pkg::LSRC_MAX : acm_pkg::LSRC_SAMPLE;
            if (count_ff == '0) begin
               cmd.op   = acm_pkg::OP_LOG_START;
               count_in = count_ff + 1'b1;
            end else begin
               cmd.op = acm_pkg::OP_LOG_STEP;
               if (count_ff == CW'(LOG_FRAC_BITS)) begin
                  count_in = '0;
                  state_in = (state_ff == S_LMIN) ? S_LMAX :
                             (state_ff == S_LMAX) ? S_LSMP : S_DIV;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_DIV: begin
            if (count_ff == '0) begin
               cmd.op   = acm_pkg::OP_DIV_START;
               count_in = count_ff + 1'b1;
            end else begin
               cmd.op = acm_pkg::OP_DIV_STEP;
               if (count_ff == CW'(9)) begin
                  state_in = S_RD;
               end
               count_in = count_ff + 1'b1;
            end
         end
         S_RD: begin
            // The palette read of the final level lands in this cycle.
            count_in = '0;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = acm_pkg::OP_FINISH;
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/acm_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_datapath
// Statistics, serial log2, restoring divider and palette memory.
// ----------------------------------------------------------------------------
module acm_datapath #(
   parameter int PALETTE_DEPTH = 256,
   parameter int LOG_FRAC_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  acm_pkg::req_type    item,
   input  acm_pkg::cmd_type    cmd,
   input  logic                palette_enable,
   output acm_pkg::status_type status,
   output acm_pkg::rsp_type    result
);

   localparam int LW = 5 + LOG_FRAC_BITS;
   localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic signed [31:0] min_ff, max_ff, sample_ff;
   logic               seen_ff, ready_ff;
   logic signed [LW-1:0] lmin_ff, lmax_ff, lsmp_ff;
   logic                 slog_ff;

   // log unit
   logic [31:0]       mant_ff;
   logic [4:0]        expo_ff;
   logic [LOG_FRAC_BITS-1:0] frac_ff;

   // divider
   logic [40:0] rem_ff;
   logic [40:0] den_ff;
   logic [8:0]  quo_ff;
   logic        zero_ff, sat_ff;

   logic [23:0] pal_mem [PALETTE_DEPTH];
   logic [23:0] pal_rd_ff;

   logic signed [31:0] lsrc_val;
   logic [31:0]        lcode;
   logic [4:0]         lpos;
   logic [63:0]        msq;
   logic [32:0]        mnext;
   logic               mbit;
   logic [LOG_FRAC_BITS-1:0] frac_nx;
   logic signed [LW-1:0] lresult;
   logic signed [40:0] xv, lov, hiv, diffv, rangev;
   logic [40:0]        trial;
   logic [7:0]         idx;

   always_comb begin
      case (cmd.lsrc)
         acm_pkg::LSRC_MIN: lsrc_val = min_ff;
         acm_pkg::LSRC_MAX: lsrc_val = max_ff;
         default:           lsrc_val = sample_ff;
      endcase
      lcode = (lsrc_val < 32'sd1) ? 32'd1 : lsrc_val;
      lpos  = 5'd0;
      for (int i = 1; i <= 30; i++) begin
         if (lcode[i]) lpos = 5'(i);
      end
      msq     = mant_ff * mant_ff;
      mnext   = 33'(msq >> 30);
      mbit    = mnext[31] || mnext[32];
      frac_nx = {frac_ff[LOG_FRAC_BITS-2:0], mbit};
      // The log is formed from the fraction after this step, so the capture
      // on the last step holds the finished value.
      lresult = LW'($signed({1'b0, expo_ff}) - 6'sd16) * LW'(1 << LOG_FRAC_BITS)
                + LW'({1'b0, frac_nx});
   end

   always_comb begin
      if (slog_ff) begin
         xv  = 41'(lsmp_ff);
         lov = 41'(lmin_ff);
         hiv = 41'(lmax_ff);
      end else begin
         xv  = 41'(sample_ff);
         lov = 41'(min_ff);
         hiv = 41'(max_ff);
      end
      diffv  = xv - lov;
      rangev = hiv - lov;
      trial  = rem_ff - den_ff;
      idx    = (zero_ff) ? 8'd0 : (sat_ff || quo_ff > 9'd255) ? 8'd255 : quo_ff[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= '0;
         seen_ff  <= 1'b0;
         lmin_ff  <= '0;
         lmax_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         case (cmd.op)
            acm_pkg::OP_LOAD: begin
               sample_ff <= item.sample;
               case (item.mode)
                  acm_pkg::MODE_MEASURE: begin
                     if (!seen_ff || item.sample < min_ff) min_ff <= item.sample;
                     if (!seen_ff || item.sample > max_ff) max_ff <= item.sample;
                     seen_ff  <= 1'b1;
                     ready_ff <= 1'b0;
                  end
                  acm_pkg::MODE_CLEAR: begin
                     min_ff   <= '0;
                     max_ff   <= '0;
                     seen_ff  <= 1'b0;
                     lmin_ff  <= '0;
                     lmax_ff  <= '0;
                     ready_ff <= 1'b0;
                  end
                  acm_pkg::MODE_MAP: slog_ff <= (min_ff >= 32'sd0);
                  default: ;
               endcase
            end
            acm_pkg::OP_LOG_START: begin
               mant_ff <= 32'(lcode << (5'd30 - lpos));
               expo_ff <= lpos;
               frac_ff <= '0;
            end
            acm_pkg::OP_LOG_STEP: begin
               if (mbit) begin
                  mant_ff <= mnext[32:1];
               end else begin
                  mant_ff <= mnext[31:0];
               end
               frac_ff <= frac_nx;
            end
            acm_pkg::OP_DIV_START: begin
               zero_ff <= (diffv <= 41'sd0) || (rangev <= 41'sd0);
               sat_ff  <= (diffv >= rangev);
               rem_ff  <= 41'(diffv) * 41'd255;
               den_ff  <= 41'(rangev) << 8;
               quo_ff  <= '0;
            end
            acm_pkg::OP_DIV_STEP: begin
               if (!trial[40]) begin
                  rem_ff <= trial;
                  quo_ff <= {quo_ff[7:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[7:0], 1'b0};
               end
               den_ff <= den_ff >> 1;
            end
            default: ;
         endcase
         // Capture the log on every step of each pass; the last step leaves the finished value.
         if (cmd.op == acm_pkg::OP_LOG_STEP) begin
            case (cmd.lsrc)
               acm_pkg::LSRC_MIN: lmin_ff <= lresult;
               acm_pkg::LSRC_MAX: begin
                  lmax_ff  <= lresult;
                  ready_ff <= 1'b1;
               end
               default: lsmp_ff <= lresult;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == acm_pkg::OP_LOAD && item.mode == acm_pkg::MODE_PAL_WRITE
          && 32'(item.pal_index) < 32'(PALETTE_DEPTH)) begin
         pal_mem[PW'(item.pal_index)] <= item.pal_rgb;
      end
      pal_rd_ff <= pal_mem[(32'(idx) < 32'(PALETTE_DEPTH)) ? PW'(idx)
                                                            : PW'(PALETTE_DEPTH - 1)];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == acm_pkg::OP_FINISH) begin
         result.color_index <= idx;
         result.log_scaled  <= slog_ff;
         result.red         <= palette_enable ? pal_rd_ff[23:16] : idx;
         result.green       <= palette_enable ? pal_rd_ff[15:8]  : idx;
         result.blue        <= palette_enable ? pal_rd_ff[7:0]   : idx;
      end
   end

   assign status.use_log    = (min_ff >= 32'sd0);
   assign status.logs_ready = ready_ff;

endmodule

@@ rtl/autoscale_false_color_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoscale_false_color_map
// Two-pass autoscaling false-color mapper, Q16.16 samples to RGB.
// ----------------------------------------------------------------------------
// Items arrive on req_ (valid/stall) and map items return one pixel on rsp_.
// Palette writes, measure and clear items leave the block idle and give no result.
// A map item in linear mode goes through the divider, the palette read and the
// output register; with a log of the sample, the serial log2 of the sample
// comes first, and on the first map after a measure or a clear the log2 of the
// bounds is computed again before it. The log2 is serial (one squaring per
// fraction bit) and the restoring divider gives one quotient bit a cycle.
// One item is in work at a time; req_stall is high while an item is in work
// or a result waits. A finished result sits in the output register until
// taken; a stalled result holds, and so does the input. Reset clears
// statistics and palette_enable; palette entries are undefined until
// written. palette_enable is written through csr_.
// ----------------------------------------------------------------------------
module autoscale_false_color_map #(
   parameter int PALETTE_DEPTH = 256,
   parameter int LOG_FRAC_BITS = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  acm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output acm_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [0:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                palette_enable_ff;
   logic                rsp_valid_ff;
   logic                busy, done, accept;
   acm_pkg::cmd_type    cmd;
   acm_pkg::status_type status;

   assign req_stall = busy || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   acm_ctrl #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .item_valid(accept), .item_mode(req_data.mode),
      .busy(busy), .status(status), .cmd(cmd), .done(done)
   );

   acm_datapath #(.PALETTE_DEPTH(PALETTE_DEPTH), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .item(req_data), .cmd(cmd),
      .palette_enable(palette_enable_ff), .status(status), .result(rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         palette_enable_ff <= 1'b0;
      end else begin
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_psel && csr_penable && csr_pwrite
             && csr_paddr == acm_pkg::REG_PALETTE_ENABLE) begin
            palette_enable_ff <= csr_pwdata[0];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, palette_enable_ff};

endmodule

@@ bench/autoscale_false_color_map_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autoscale_false_color_map_tb
// Self-checking bench for the autoscaling false-color mapper.
// ----------------------------------------------------------------------------
// Random bursts of palette writes, measure runs, map runs and clears are fed
// on the request channel while the response side stalls on its own pattern.
// A scoreboard class keeps its own copy of the statistics, log bounds and
// palette, predicts each pixel and compares it field by field.
// ----------------------------------------------------------------------------
module autoscale_false_color_map_tb;

   class pixel_scoreboard;
      bit               pal_on;
      logic signed [31:0] lo_code, hi_code;
      bit               seen;
      int               lg_lo, lg_hi;
      bit               lg_valid;
      logic [23:0]      colors [256];
      acm_pkg::rsp_type pending [$];
      int               errors;

      function void clear_stats();
         lo_code = 0; hi_code = 0; seen = 0;
         lg_lo = 0; lg_hi = 0; lg_valid = 0;
      endfunction

      function int log2_q10(logic signed [31:0] code);
         logic [31:0] c;
         logic [63:0] m;
         int p, f;
         c = (code < 1) ? 32'd1 : code;
         p = 30;
         f = 0;
         while (p > 0 && c[p] == 1'b0) p--;
         m = 64'(c) << (30 - p);
         for (int k = 0; k < 10; k++) begin
            m = (m * m) >> 30;
            f = f * 2;
            if (m >= (64'd1 << 31)) begin
               f += 1;
               m >>= 1;
            end
         end
         return (p - 16) * 1024 + f;
      endfunction

      function logic [7:0] level(longint x, longint lo, longint hi);
         longint q;
         if (hi == lo || x - lo <= 0 || hi - lo <= 0) return 8'd0;
         q = ((x - lo) * 255) / (hi - lo);
         return (q > 255) ? 8'd255 : 8'(q);
      endfunction

      function void note_request(acm_pkg::req_type r);
         acm_pkg::rsp_type e;
         logic [23:0] rgb;
         case (r.mode)
            acm_pkg::MODE_PAL_WRITE: colors[r.pal_index] = r.pal_rgb;
            acm_pkg::MODE_MEASURE: begin
               if (!seen) begin
                  lo_code = r.sample; hi_code = r.sample; seen = 1;
               end else begin
                  if (r.sample < lo_code) lo_code = r.sample;
                  if (r.sample > hi_code) hi_code = r.sample;
               end
               lg_valid = 0;
            end
            acm_pkg::MODE_CLEAR: clear_stats();
            default: begin
               e.log_scaled = (lo_code >= 0);
               if (e.log_scaled) begin
                  if (!lg_valid) begin
                     lg_lo = log2_q10(lo_code);
                     lg_hi = log2_q10(hi_code);
                     lg_valid = 1;
                  end
                  e.color_index = level(log2_q10(r.sample), lg_lo, lg_hi);
               end else begin
                  e.color_index = level(r.sample, lo_code, hi_code);
               end
               rgb = pal_on ? colors[e.color_index] : {3{e.color_index}};
               {e.red, e.green, e.blue} = rgb;
               pending.push_back(e);
            end
         endcase
      endfunction

      function void check_pixel(acm_pkg::rsp_type a);
         acm_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected pixel %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.color_index !== e.color_index) begin
            $error("color_index exp %0d got %0d", e.color_index, a.color_index); errors++;
         end
         if (a.red !== e.red) begin
            $error("red exp %0d got %0d", e.red, a.red); errors++;
         end
         if (a.green !== e.green) begin
            $error("green exp %0d got %0d", e.green, a.green); errors++;
         end
         if (a.blue !== e.blue) begin
            $error("blue exp %0d got %0d", e.blue, a.blue); errors++;
         end
         if (a.log_scaled !== e.log_scaled) begin
            $error("log_scaled exp %0d got %0d", e.log_scaled, a.log_scaled); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   acm_pkg::req_type req_data;
   acm_pkg::rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [0:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   pixel_scoreboard sb;
   int cycles;
   bit hold_rsp;
   bit idle_gaps;

   autoscale_false_color_map u_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("autoscale_false_color_map regression: fail");
         $finish;
      end
   end

   // Response side: its own stall pattern, or a long hold when asked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
      if (hold_rsp) rsp_stall <= 1'b1;
      else if (cycles % 200 < 60) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   task automatic send(acm_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (idle_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_item(logic [1:0] m, logic [31:0] s, logic [7:0] pi, logic [23:0] rgb);
      acm_pkg::req_type r;
      r.mode = m; r.sample = s; r.pal_index = pi; r.pal_rgb = rgb;
      send(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic [31:0] v);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= acm_pkg::REG_PALETTE_ENABLE; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.pal_on = v[0];
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_sample(int kind);
      case (kind)
         0: return $urandom();
         1: return $urandom_range(0, 32'h7FFF_FFFF);
         2: return $urandom_range(0, 2000);
         default: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< $urandom_range(0, 16);
      endcase
   endfunction

   initial begin
      int kind;
      sb = new();
      sb.clear_stats();
      sb.pal_on = 0;
      cycles = 0;
      hold_rsp = 0;
      idle_gaps = 1;
      reset = 1;
      req_valid = 0; req_data = '0; rsp_stall = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: map before measure, equal bounds, log clamp, extremes.
      send_item(acm_pkg::MODE_MAP, 32'h1234_5678, 0, 0);
      send_item(acm_pkg::MODE_MEASURE, 32'd65536, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd65536, 0, 0);
      send_item(acm_pkg::MODE_MEASURE, 32'h7FFF_FFFF, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd0, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'h8000_0000, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'h7FFF_FFFF, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd1000000, 0, 0);
      send_item(acm_pkg::MODE_MEASURE, 32'h8000_0000, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'h8000_0000, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'h7FFF_FFFF, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd0, 0, 0);
      send_item(acm_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF);
      send_item(acm_pkg::MODE_MEASURE, 32'd0, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd5, 0, 0);
      send_item(acm_pkg::MODE_MEASURE, 32'd300, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'hFFFF_FFF0, 0, 0);
      send_item(acm_pkg::MODE_MAP, 32'd150, 0, 0);
      drain();

      // Fill the whole palette so every lookup hits a written entry.
      for (int i = 0; i < 256; i++)
         send_item(acm_pkg::MODE_PAL_WRITE, $urandom(), 8'(i), $urandom());
      send_item(acm_pkg::MODE_PAL_WRITE, 0, 8'h00, 24'h000000);
      send_item(acm_pkg::MODE_PAL_WRITE, 0, 8'hFF, 24'hFFFFFF);
      drain();
      csr_write(32'h1);

      for (int phase = 0; phase < 4; phase++) begin
         idle_gaps = (phase != 2);
         for (int n = 0; n < 230; n++) begin
            case ($urandom_range(0, 19))
               0: send_item(acm_pkg::MODE_CLEAR, $urandom(), $urandom(), $urandom());
               1: send_item(acm_pkg::MODE_PAL_WRITE, $urandom(), $urandom(), $urandom());
               2, 3, 4: begin
                  kind = $urandom_range(0, 3);
                  repeat ($urandom_range(1, 4))
                     send_item(acm_pkg::MODE_MEASURE, rand_sample(kind), $urandom(),
                               $urandom());
               end
               default: begin
                  kind = $urandom_range(0, 3);
                  send_item(acm_pkg::MODE_MAP, rand_sample(kind), $urandom(), $urandom());
               end
            endcase
            if (phase == 1 && n == 100) begin
               // Long response hold while requests keep coming.
               fork
                  begin
                     hold_rsp = 1;
                     repeat (400) @(posedge clock);
                     hold_rsp = 0;
                  end
               join_none
            end
            if (n == 200) drain();
         end
         drain();
         csr_write({31'($urandom()), phase[0]});
      end
      csr_write(32'h0);
      for (int n = 0; n < 60; n++)
         send_item(n % 3 == 0 ? acm_pkg::MODE_MEASURE : acm_pkg::MODE_MAP,
                   rand_sample(n % 4), 0, 0);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("autoscale_false_color_map regression: pass");
      else
         $display("autoscale_false_color_map regression: fail");
      $finish;
   end
endmodule
